[rtl/nrp_pkg.sv]
// Nested region profiler: shared types, field widths and codes.
// Used by nested_region_profiler and nrp_counter_store. No dependencies.
package nrp_pkg;

  localparam int IDX_W       = 12;
  localparam int TS_W        = 64;
  localparam int ACT_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int CNT_W       = 64;
  localparam int DEPTH_OUT_W = 7;

  localparam int DEF_ANCHOR_SLOTS = 4096;
  localparam int DEF_NEST_DEPTH   = 64;

  localparam logic [ACT_W-1:0] ACT_ENTER = 2'd0;
  localparam logic [ACT_W-1:0] ACT_EXIT  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVER  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDER = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [IDX_W-1:0] anchor_index;
    logic [TS_W-1:0]  timestamp;
  } nrp_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [CNT_W-1:0]       total_elapsed;
    logic [CNT_W-1:0]       children_elapsed;
    logic [CNT_W-1:0]       hit_count;
    logic [DEPTH_OUT_W-1:0] open_depth;
  } nrp_out_t;

  // Counter memory port controls.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } nrp_mem_ctrl_t;

endpackage

[rtl/nrp_counter_store.sv]
// Per-anchor counter memory with a zeroing sweep after reset.
// Depends on nrp_pkg (nrp_mem_ctrl_t, DEF_ANCHOR_SLOTS).
module nrp_counter_store import nrp_pkg::*; #(
  parameter int ANCHOR_SLOTS = DEF_ANCHOR_SLOTS,
  parameter int ROW_W        = 200
) (
  input  logic                            clk,
  input  logic                            rst,
  input  nrp_mem_ctrl_t                   ctrl,
  input  logic [$clog2(ANCHOR_SLOTS)-1:0] rd_addr,
  input  logic [$clog2(ANCHOR_SLOTS)-1:0] wr_addr,
  input  logic [ROW_W-1:0]                wr_data,
  output logic [ROW_W-1:0]                rd_data,
  output logic                            busy
);

  localparam int AW = $clog2(ANCHOR_SLOTS);

  logic [ROW_W-1:0] mem [ANCHOR_SLOTS];
  logic [AW-1:0]    clr_addr;
  logic             we;
  logic [AW-1:0]    wa;
  logic [ROW_W-1:0] wd;

  // sweep owns the write port until every row is zero
  assign we = busy | ctrl.wr_en;
  assign wa = busy ? clr_addr : wr_addr;
  assign wd = busy ? '0 : wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(ANCHOR_SLOTS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (ctrl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/nested_region_profiler.sv]
// Nested region profiler. An enter reads its slot row and writes it back; an exit reads
// the region stack, then read-modify-writes the anchor row and, for an outermost exit
// while the current anchor is not root, also the parent's children total. Items are
// taken one at a time, only while the FSM is idle: one counter memory port does every
// read-modify-write in sequence. After reset the counter memory is zeroed one row a
// cycle (ANCHOR_SLOTS rows, 4096 by default); evt_stall holds.
module nested_region_profiler import nrp_pkg::*; #(
  parameter int ANCHOR_SLOTS = DEF_ANCHOR_SLOTS,
  parameter int NEST_DEPTH   = DEF_NEST_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     evt_valid,
  output logic     evt_stall,
  input  nrp_in_t  evt,
  output logic     res_valid,
  input  logic     res_stall,
  output nrp_out_t res
);

  localparam int AW  = $clog2(ANCHOR_SLOTS);
  localparam int DW  = $clog2(NEST_DEPTH + 1);   // per-anchor depth and stack pointer
  localparam int SIW = $clog2(NEST_DEPTH);       // stack index

  // Slot = anchor_index mod ANCHOR_SLOTS via exact reciprocal multiply:
  // q = (idx * MOD_MULT) >> MOD_SHIFT is floor(idx / ANCHOR_SLOTS) for any 12-bit idx.
  localparam int    MOD_SHIFT = IDX_W + $clog2(ANCHOR_SLOTS);
  localparam longint MOD_MULT =
    ((longint'(1) << MOD_SHIFT) + ANCHOR_SLOTS - 1) / ANCHOR_SLOTS;

  // FSM codes
  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DISPATCH = 4'd2;
  localparam logic [3:0] S_ENTER_WB = 4'd3;
  localparam logic [3:0] S_READ_RSP = 4'd4;
  localparam logic [3:0] S_EX_STACK = 4'd5;
  localparam logic [3:0] S_EX_AWB   = 4'd6;
  localparam logic [3:0] S_EX_PRD   = 4'd7;
  localparam logic [3:0] S_EX_PWB   = 4'd8;
  localparam logic [3:0] S_RESP     = 4'd9;

  // One counter memory row per anchor slot.
  typedef struct packed {
    logic [CNT_W-1:0] elapsed;
    logic [CNT_W-1:0] children;
    logic [CNT_W-1:0] hits;
    logic [DW-1:0]    depth;
  } row_t;

  // One region stack entry.
  typedef struct packed {
    logic [TS_W-1:0] start;
    logic [AW-1:0]   anchor;
    logic [AW-1:0]   parent;
  } stk_t;

  localparam int ROW_W = $bits(row_t);

  // control state
  logic [3:0]          state, state_next;
  logic [DW-1:0]       sp, sp_next;        // region stack pointer
  logic [AW-1:0]       cur, cur_next;      // current anchor
  // item payload and scratch
  nrp_in_t             item;
  logic [IDX_W-1:0]    q_reg;
  logic [AW-1:0]       slot, slot_next;
  logic [CNT_W-1:0]    el_reg, el_next;
  logic [STATUS_W-1:0] status_pend, status_next;

  logic                accept;
  logic                out_free;
  logic [31:0]         mod_prod;
  logic [IDX_W-1:0]    rem;
  logic [AW-1:0]       slot_calc;

  // counter memory port
  nrp_mem_ctrl_t       mem_ctrl;
  logic [AW-1:0]       mem_raddr, mem_waddr;
  logic [ROW_W-1:0]    mem_rdata;
  row_t                row_rd, row_wr;
  logic                clr_busy;

  // region stack memory
  stk_t                stk_mem [NEST_DEPTH];
  stk_t                stk_rd, stk_wdata;
  logic                stk_re, stk_we;
  logic [SIW-1:0]      stk_raddr, stk_waddr;

  // exit arithmetic
  logic [CNT_W-1:0]    el;
  logic                outer;
  logic                chain;

  // result staging
  logic                emit;
  nrp_out_t            emit_item;

  assign accept   = evt_valid && !evt_stall;
  assign evt_stall = (state != S_IDLE);
  assign out_free = !res_valid || !res_stall;

  assign mod_prod  = 32'(evt.anchor_index) * 32'(MOD_MULT);
  assign rem       = item.anchor_index - IDX_W'(32'(q_reg) * 32'(ANCHOR_SLOTS));
  assign slot_calc = AW'(rem);

  assign row_rd    = row_t'(mem_rdata);
  assign stk_raddr = SIW'(sp - 1'b1);
  assign stk_waddr = SIW'(sp);

  // elapsed wraps mod 2^64; only outermost exits of a slot count toward totals
  assign el    = item.timestamp - stk_rd.start;
  assign outer = (row_rd.depth <= DW'(1));
  assign chain = outer && (cur != '0);

  nrp_counter_store #(
    .ANCHOR_SLOTS(ANCHOR_SLOTS),
    .ROW_W       (ROW_W)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mem_ctrl),
    .rd_addr(mem_raddr),
    .wr_addr(mem_waddr),
    .wr_data(row_wr),
    .rd_data(mem_rdata),
    .busy   (clr_busy)
  );

  always_comb begin
    state_next  = state;
    sp_next     = sp;
    cur_next    = cur;
    slot_next   = slot;
    el_next     = el_reg;
    status_next = status_pend;
    mem_ctrl    = '0;
    mem_raddr   = slot_calc;
    mem_waddr   = slot;
    row_wr      = row_rd;
    stk_re      = 1'b0;
    stk_we      = 1'b0;
    stk_wdata   = '{start: item.timestamp, anchor: slot, parent: cur};
    emit        = 1'b0;
    emit_item   = '0;

    unique case (state)
      S_CLEAR: begin
        if (!clr_busy) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        slot_next = slot_calc;
        unique case (item.action)
          ACT_ENTER: begin
            if (sp == DW'(NEST_DEPTH)) begin
              status_next = ST_OVER;
              state_next  = S_RESP;
            end else begin
              mem_ctrl.rd_en = 1'b1;
              state_next     = S_ENTER_WB;
            end
          end
          ACT_EXIT: begin
            if (sp == '0) begin
              status_next = ST_UNDER;
              state_next  = S_RESP;
            end else begin
              stk_re     = 1'b1;
              state_next = S_EX_STACK;
            end
          end
          ACT_READ: begin
            mem_ctrl.rd_en = 1'b1;
            state_next     = S_READ_RSP;
          end
          default: begin
            // unused action: all-zero result
            status_next = ST_OK;
            state_next  = S_RESP;
          end
        endcase
      end
      S_ENTER_WB: begin
        if (out_free) begin
          row_wr.depth   = row_rd.depth + 1'b1;
          mem_ctrl.wr_en = 1'b1;
          stk_we         = 1'b1;
          sp_next        = sp + 1'b1;
          if (row_rd.depth == '0) begin
            cur_next = slot;
          end
          emit             = 1'b1;
          emit_item.status = ST_OK;
          state_next       = S_IDLE;
        end
      end
      S_READ_RSP: begin
        if (out_free) begin
          emit                       = 1'b1;
          emit_item.status           = ST_OK;
          emit_item.total_elapsed    = row_rd.elapsed;
          emit_item.children_elapsed = row_rd.children;
          emit_item.hit_count        = row_rd.hits;
          emit_item.open_depth       = DEPTH_OUT_W'(row_rd.depth);
          state_next                 = S_IDLE;
        end
      end
      S_EX_STACK: begin
        mem_ctrl.rd_en = 1'b1;
        mem_raddr      = stk_rd.anchor;
        state_next     = S_EX_AWB;
      end
      S_EX_AWB: begin
        // parent update follows when chained, so the result waits for it
        if (chain || out_free) begin
          mem_waddr      = stk_rd.anchor;
          mem_ctrl.wr_en = 1'b1;
          row_wr.elapsed = outer ? row_rd.elapsed + el : row_rd.elapsed;
          row_wr.hits    = row_rd.hits + 1'b1;
          row_wr.depth   = (row_rd.depth != '0) ? row_rd.depth - 1'b1 : row_rd.depth;
          sp_next        = sp - 1'b1;
          el_next        = el;
          if (outer) begin
            cur_next = stk_rd.parent;
          end
          if (chain) begin
            state_next = S_EX_PRD;
          end else begin
            emit             = 1'b1;
            emit_item.status = ST_OK;
            state_next       = S_IDLE;
          end
        end
      end
      S_EX_PRD: begin
        // separate read after the anchor write: parent may equal anchor
        mem_ctrl.rd_en = 1'b1;
        mem_raddr      = stk_rd.parent;
        state_next     = S_EX_PWB;
      end
      S_EX_PWB: begin
        if (out_free) begin
          mem_waddr        = stk_rd.parent;
          mem_ctrl.wr_en   = 1'b1;
          row_wr.children  = row_rd.children + el_reg;
          emit             = 1'b1;
          emit_item.status = ST_OK;
          state_next       = S_IDLE;
        end
      end
      S_RESP: begin
        if (out_free) begin
          emit             = 1'b1;
          emit_item.status = status_pend;
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      sp    <= '0;
      cur   <= '0;
    end else begin
      state <= state_next;
      sp    <= sp_next;
      cur   <= cur_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item  <= evt;
      q_reg <= IDX_W'(mod_prod >> MOD_SHIFT);
    end
    slot        <= slot_next;
    el_reg      <= el_next;
    status_pend <= status_next;
  end

  // region stack memory, registered read
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rd <= stk_mem[stk_raddr];
    end
  end

  // output register: frees the FSM while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res <= emit_item;
    end
  end

  // stack never grows past its depth
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= DW'(NEST_DEPTH))
    else $error("region stack pointer beyond depth");

  // empty stack means the root slot is current
  a_root_when_empty: assert property (@(posedge clk) disable iff (rst)
    (sp == '0) |-> (cur == '0))
    else $error("current anchor not root with empty stack");

  // a pushed region keeps its slot depth above zero
  a_depth_open: assert property (@(posedge clk) disable iff (rst)
    (state == S_EX_AWB) |-> (row_rd.depth != '0))
    else $error("exit found zero depth for pushed anchor");

  // stack pointer moves only on enter or exit writeback
  a_sp_moves: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(sp)) |->
      ($past(state) == S_ENTER_WB || $past(state) == S_EX_AWB))
    else $error("stack pointer changed outside writeback");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for nested_region_profiler: nested enter/exit/read traffic
// with random handshake idling, checked against a scoreboard-held predictor.
// Depends on nrp_pkg and the profiler RTL only.

module testbench;
  import nrp_pkg::*;

  // Action code 3 has no name in the package; the block must treat it as a no-op.
  localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;

  localparam int SLOTS        = DEF_ANCHOR_SLOTS;
  localparam int NEST         = DEF_NEST_DEPTH;
  localparam int RANDOM_ITEMS = 1650;

  // Predicts every result of the profiler and holds them until they come out.
  class region_scoreboard;
    logic [CNT_W-1:0]       total_tbl [SLOTS];
    logic [CNT_W-1:0]       child_tbl [SLOTS];
    logic [CNT_W-1:0]       hit_tbl   [SLOTS];
    logic [DEPTH_OUT_W-1:0] depth_tbl [SLOTS];
    logic [IDX_W-1:0]       cur_anchor;
    logic [TS_W-1:0]        open_start  [NEST];
    logic [IDX_W-1:0]       open_anchor [NEST];
    logic [IDX_W-1:0]       open_parent [NEST];
    int                     open_count;
    nrp_out_t               expected_q [$];
    int                     errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        total_tbl[i] = '0;
        child_tbl[i] = '0;
        hit_tbl[i]   = '0;
        depth_tbl[i] = '0;
      end
      cur_anchor = '0;
      open_count = 0;
      errors     = 0;
    endfunction

    // Apply one accepted item to the shadow state and queue its result.
    function void note_event(nrp_in_t e);
      nrp_out_t         r;
      logic [IDX_W-1:0] a;
      logic [IDX_W-1:0] p;
      logic [TS_W-1:0]  el;
      r = '0;
      case (e.action)
        ACT_ENTER: begin
          if (open_count >= NEST) begin
            r.status = ST_OVER;
          end else begin
            depth_tbl[e.anchor_index] = depth_tbl[e.anchor_index] + 7'd1;
            open_anchor[open_count] = e.anchor_index;
            open_start[open_count]  = e.timestamp;
            open_parent[open_count] = cur_anchor;
            open_count++;
            if (depth_tbl[e.anchor_index] <= 7'd1) cur_anchor = e.anchor_index;
            r.status = ST_OK;
          end
        end
        ACT_EXIT: begin
          if (open_count == 0) begin
            r.status = ST_UNDER;
          end else begin
            open_count--;
            a  = open_anchor[open_count];
            p  = open_parent[open_count];
            el = e.timestamp - open_start[open_count];
            if (depth_tbl[a] <= 7'd1) begin
              total_tbl[a] = total_tbl[a] + el;
              if (cur_anchor != '0) child_tbl[p] = child_tbl[p] + el;
              cur_anchor = p;
            end
            hit_tbl[a] = hit_tbl[a] + 64'd1;
            if (depth_tbl[a] > 7'd0) depth_tbl[a] = depth_tbl[a] - 7'd1;
            r.status = ST_OK;
          end
        end
        ACT_READ: begin
          r.status           = ST_OK;
          r.total_elapsed    = total_tbl[e.anchor_index];
          r.children_elapsed = child_tbl[e.anchor_index];
          r.hit_count        = hit_tbl[e.anchor_index];
          r.open_depth       = depth_tbl[e.anchor_index];
        end
        default: r = '0;
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
      if (want !== got) begin
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(nrp_out_t got);
      nrp_out_t want;
      if (expected_q.size() == 0) begin
        $display("%0t ns: result with nothing expected, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      check_field("status", CNT_W'(want.status), CNT_W'(got.status));
      check_field("total_elapsed", want.total_elapsed, got.total_elapsed);
      check_field("children_elapsed", want.children_elapsed, got.children_elapsed);
      check_field("hit_count", want.hit_count, got.hit_count);
      check_field("open_depth", CNT_W'(want.open_depth), CNT_W'(got.open_depth));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     evt_valid = 1'b0;
  logic     evt_stall;
  nrp_in_t  evt       = '0;
  logic     res_valid;
  logic     res_stall = 1'b0;
  nrp_out_t res;

  region_scoreboard sb = new();

  nested_region_profiler dut (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  initial forever #10 clk = ~clk;

  // Hard stop: normal runs finish in well under a tenth of this.
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Handshake monitor. Runs in the active region of the edge, so it sees the
  // values that the block itself samples at that edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (evt_valid && !evt_stall) sb.note_event(evt);
      if (res_valid && !res_stall) sb.check_result(res);
    end
  end

  // Result-side backpressure: short random stall bursts, interleaved with
  // occasional long calm stretches where every result flows straight out.
  int stall_run = 0;
  always @(posedge clk) begin
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else begin
      case ($urandom_range(0, 9))
        0: begin
          res_stall <= 1'b0;
          stall_run <= $urandom_range(40, 250);
        end
        1, 2, 3: begin
          res_stall <= 1'b1;
          stall_run <= $urandom_range(0, 5);
        end
        default: begin
          res_stall <= 1'b0;
          stall_run <= $urandom_range(0, 8);
        end
      endcase
    end
  end

  // Sender state. gen_depth mirrors the region stack depth the block will see,
  // so the generator can steer toward well-formed nesting.
  int               burst_left = 0;
  int               gen_depth  = 0;
  int               items_sent = 0;
  logic [TS_W-1:0]  ts_now;
  logic [IDX_W-1:0] anchor_pool [8];

  function automatic nrp_in_t make_item(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
                                        logic [TS_W-1:0] ts);
    nrp_in_t it;
    it.action       = act;
    it.anchor_index = idx;
    it.timestamp    = ts;
    return it;
  endfunction

  // Mostly a forward-running clock; now and then a big jump, and sometimes a
  // stray value so that elapsed times wrap.
  function automatic logic [TS_W-1:0] next_ts();
    case ($urandom_range(0, 19))
      0: return {$urandom, $urandom};
      1: ts_now = ts_now + {$urandom, $urandom};
      default: ts_now = ts_now + TS_W'($urandom_range(1, 300));
    endcase
    return ts_now;
  endfunction

  // A small pool keeps recursion and re-entry common; a few picks go anywhere.
  function automatic logic [IDX_W-1:0] pick_anchor();
    if ($urandom_range(0, 6) == 0) return IDX_W'($urandom_range(0, SLOTS - 1));
    return anchor_pool[$urandom_range(0, 7)];
  endfunction

  // Present one item and hold it until accepted. Bursts of random length are
  // separated by random gaps with valid low.
  task automatic send_item(input nrp_in_t item);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        evt_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    evt       <= item;
    evt_valid <= 1'b1;
    @(posedge clk);
    while (evt_stall) @(posedge clk);
    items_sent++;
    if (item.action == ACT_ENTER && gen_depth < NEST) gen_depth++;
    else if (item.action == ACT_EXIT && gen_depth > 0) gen_depth--;
  endtask

  // One random item, biased toward opening regions while the stack is shallow.
  task automatic random_step();
    int roll;
    int enter_cut;
    roll      = $urandom_range(0, 99);
    enter_cut = (gen_depth < 4) ? 70 : (gen_depth < 12) ? 58 : 45;
    if (roll < 2)
      send_item(make_item(ACT_NOP, IDX_W'($urandom_range(0, SLOTS - 1)),
                          {$urandom, $urandom}));
    else if (roll < 22)
      send_item(make_item(ACT_READ, pick_anchor(), next_ts()));
    else if (gen_depth == 0 && roll < 28)
      send_item(make_item(ACT_EXIT, IDX_W'($urandom_range(0, SLOTS - 1)),
                          next_ts()));  // underflow
    else if (gen_depth == 0 || roll < enter_cut)
      send_item(make_item(ACT_ENTER, pick_anchor(), next_ts()));
    else
      send_item(make_item(ACT_EXIT, IDX_W'($urandom_range(0, SLOTS - 1)), next_ts()));
  endtask

  // Fill the region stack to the top, knock on it twice (overflow), then
  // unwind completely and pop once more (underflow). Reads sprinkled in.
  task automatic fill_and_drain();
    while (gen_depth < NEST) begin
      if ($urandom_range(0, 9) == 0) send_item(make_item(ACT_READ, pick_anchor(), next_ts()));
      else send_item(make_item(ACT_ENTER, pick_anchor(), next_ts()));
    end
    repeat (2) send_item(make_item(ACT_ENTER, pick_anchor(), next_ts()));
    send_item(make_item(ACT_READ, pick_anchor(), next_ts()));
    while (gen_depth > 0) begin
      if ($urandom_range(0, 9) == 0) send_item(make_item(ACT_READ, pick_anchor(), next_ts()));
      else send_item(make_item(ACT_EXIT, IDX_W'($urandom_range(0, SLOTS - 1)), next_ts()));
    end
    send_item(make_item(ACT_EXIT, IDX_W'($urandom_range(0, SLOTS - 1)), next_ts()));
  endtask

  initial begin
    int stop_at;
    int dive_at;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    ts_now      = {$urandom, $urandom};
    anchor_pool = '{12'd0, 12'd1, 12'd2, 12'd7, 12'hFFF, 12'hAAA, 12'h555, 12'd0};
    anchor_pool[7] = IDX_W'($urandom_range(0, SLOTS - 1));

    // Directed opening. The block holds evt_stall through its clearing pass,
    // so the first item simply waits for the handshake.
    send_item(make_item(ACT_READ, 12'd0, 64'd0));                 // fresh counters read zero
    send_item(make_item(ACT_EXIT, 12'hFFF, '1));                  // pop from empty stack
    send_item(make_item(ACT_NOP, 12'hFFF, '1));                   // unused action code
    send_item(make_item(ACT_NOP, 12'd0, 64'd0));
    send_item(make_item(ACT_ENTER, 12'hFFF, 64'hFFFF_FFFF_FFFF_FF00));
    send_item(make_item(ACT_ENTER, 12'd1, 64'hFFFF_FFFF_FFFF_FF10));
    send_item(make_item(ACT_ENTER, 12'd1, 64'hFFFF_FFFF_FFFF_FF20)); // recursion, depth 2
    send_item(make_item(ACT_EXIT, 12'd0, 64'hFFFF_FFFF_FFFF_FF30));  // inner exit, hit only
    send_item(make_item(ACT_READ, 12'd1, 64'd0));
    // outermost exit of slot 1: timestamp wrapped past 2^64, credits slot 4095
    send_item(make_item(ACT_EXIT, 12'd0, 64'h40));
    // outermost exit of slot 4095 while it is current: parent is root
    send_item(make_item(ACT_EXIT, 12'd0, 64'h80));
    send_item(make_item(ACT_READ, 12'hFFF, 64'd0));
    send_item(make_item(ACT_READ, 12'd1, 64'd0));
    send_item(make_item(ACT_READ, 12'd0, 64'd0));
    // root slot entered explicitly, with a child under it
    send_item(make_item(ACT_ENTER, 12'd0, 64'd100));
    send_item(make_item(ACT_ENTER, 12'd2, 64'd150));
    send_item(make_item(ACT_EXIT, 12'd0, 64'd400));
    send_item(make_item(ACT_EXIT, 12'd0, 64'd1000));              // current is root: no credit
    send_item(make_item(ACT_READ, 12'd0, 64'd0));
    send_item(make_item(ACT_READ, 12'd2, 64'd0));

    // Random traffic with a full-stack dive every few hundred items.
    stop_at = items_sent + RANDOM_ITEMS;
    dive_at = items_sent + $urandom_range(50, 400);
    while (items_sent < stop_at) begin
      if (items_sent >= dive_at) begin
        fill_and_drain();
        dive_at = items_sent + $urandom_range(300, 700);
      end else begin
        random_step();
      end
    end
    evt_valid <= 1'b0;

    // Drain, then give the block time to show any stray result.
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

[filelist.f]
rtl/nrp_pkg.sv
rtl/nrp_counter_store.sv
rtl/nested_region_profiler.sv
verif/testbench.sv
